### rtl/rwm_pkg.sv
// Shared types and constants for the random walk modulator.
// No dependencies; imported by rwm_ctrl, rwm_datapath and the top level.
package rwm_pkg;

    localparam logic [31:0] LCG_MUL     = 32'd1664525;
    localparam logic [31:0] LCG_ADD     = 32'd1013904223;
    localparam logic signed [31:0] SCALE_Q31 = 32'sd644245120;
    localparam logic signed [31:0] POS_LIMIT = 32'sd1717986944;
    localparam logic signed [31:0] NEG_LIMIT = -32'sd1717986944;

    localparam logic [31:0] SEED_RESET = 32'd1;
    localparam logic [30:0] STEP_RESET = 31'd2147483;

    // register byte-address bit that picks a register
    localparam logic REG_SEED = 1'b0;
    localparam logic REG_STEP = 1'b1;

    typedef struct packed {
        logic load;     // capture an input beat
        logic reload;   // restart: state from seed, levels to zero
        logic measure;  // form distance, compare with step
        logic move;     // move current level one step
        logic lcg;      // snap to target, advance generator
        logic scale;    // scale generator output
        logic target;   // form new target
        logic push;     // load output register
    } rwm_cmd_t;

    typedef struct packed {
        logic restart;  // captured beat asks for restart
        logic reach;    // target within one step
        logic out_free; // output register can take a beat
    } rwm_stat_t;

endpackage

### rtl/rwm_ctrl.sv
// Sequencer for the random walk modulator.
// Depends on rwm_pkg for the command and status structs.
module rwm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  rwm_pkg::rwm_stat_t stat,
    output rwm_pkg::rwm_cmd_t  cmd
);
    import rwm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_BRANCH,
        ST_SCALE,
        ST_TARGET,
        ST_PUSH
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.restart) begin
                    cmd.reload = 1'b1;
                    state_next = ST_PUSH;
                end else begin
                    cmd.measure = 1'b1;
                    state_next  = ST_BRANCH;
                end
            end
            ST_BRANCH: begin
                if (stat.reach) begin
                    cmd.lcg    = 1'b1;
                    state_next = ST_SCALE;
                end else begin
                    cmd.move   = 1'b1;
                    state_next = ST_PUSH;
                end
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_TARGET;
            end
            ST_TARGET: begin
                cmd.target = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                // hold until the previous beat has left the output register
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/rwm_datapath.sv
// Level, target and generator registers with their arithmetic, plus the output register.
// Depends on rwm_pkg; driven by commands from rwm_ctrl.
module rwm_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  rwm_pkg::rwm_cmd_t  cmd,
    output rwm_pkg::rwm_stat_t stat,
    input  logic               in_restart,
    input  logic [31:0]        seed_value,
    input  logic [30:0]        step_incr,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [31:0]        m_tdata,
    output logic               m_tuser
);
    import rwm_pkg::*;

    localparam logic signed [31:0] Q31_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q31_MIN = 32'sh8000_0000;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v > 33'sh0_7FFF_FFFF) begin
            return Q31_MAX;
        end else if (v < 33'sh1_8000_0000) begin
            return Q31_MIN;
        end else begin
            return v[31:0];
        end
    endfunction

    logic [31:0]        rng_reg;
    logic signed [31:0] cur_reg;
    logic signed [31:0] tgt_reg;
    logic               restart_reg;
    logic               reach_reg;
    logic               pos_reg;
    logic signed [63:0] prod_reg;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;
    logic               m_tuser_reg;

    logic signed [31:0] dist_w;
    logic signed [32:0] dist_cmp_w;
    logic signed [32:0] step_w;
    logic               reach_w;
    logic signed [31:0] moved_w;
    logic [31:0]        lcg_w;
    logic signed [31:0] off_w;
    logic signed [31:0] sum_w;
    logic signed [31:0] clamp_w;

    always_comb begin
        step_w = $signed({2'b00, step_incr});
        dist_w = sat33($signed({tgt_reg[31], tgt_reg}) - $signed({cur_reg[31], cur_reg}));
        // most negative distance saturates in magnitude: compare as one above it
        dist_cmp_w = (dist_w == Q31_MIN) ? $signed({1'b1, Q31_MIN + 32'sd1})
                                         : $signed({dist_w[31], dist_w});
        reach_w = (dist_cmp_w <= step_w) && (dist_cmp_w >= -step_w);

        if (pos_reg) begin
            moved_w = sat33($signed({cur_reg[31], cur_reg}) + step_w);
        end else begin
            moved_w = sat33($signed({cur_reg[31], cur_reg}) - step_w);
        end

        lcg_w = rng_reg * LCG_MUL + LCG_ADD;

        off_w = prod_reg[62:31];
        sum_w = sat33($signed({cur_reg[31], cur_reg}) + $signed({off_w[31], off_w}));
        priority if (sum_w > POS_LIMIT) begin
            clamp_w = POS_LIMIT;
        end else if (sum_w < NEG_LIMIT) begin
            clamp_w = NEG_LIMIT;
        end else begin
            clamp_w = sum_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rng_reg      <= SEED_RESET;
            cur_reg      <= '0;
            tgt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.reload) begin
                rng_reg <= seed_value;
                cur_reg <= '0;
                tgt_reg <= '0;
            end
            if (cmd.move) begin
                cur_reg <= moved_w;
            end
            if (cmd.lcg) begin
                cur_reg <= tgt_reg;
                rng_reg <= lcg_w;
            end
            if (cmd.target) begin
                tgt_reg <= clamp_w;
            end
            if (cmd.push) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            restart_reg <= in_restart;
        end
        if (cmd.reload) begin
            reach_reg <= 1'b0;
        end
        if (cmd.measure) begin
            reach_reg <= reach_w;
            pos_reg   <= (dist_w > 32'sd0);
        end
        if (cmd.scale) begin
            prod_reg <= $signed(rng_reg) * SCALE_Q31;
        end
        if (cmd.push) begin
            m_tdata_reg <= cur_reg;
            m_tuser_reg <= reach_reg;
        end
    end

    assign stat.restart  = restart_reg;
    assign stat.reach    = reach_reg;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/random_walk_modulator_top.sv
// Top level of the random walk modulator: register port, sequencer and datapath.
// Depends on rwm_pkg, rwm_ctrl and rwm_datapath.
//
// Q31 random-walk modulation source. Each input beat is one tick (or a restart,
// which reloads the generator from seed_value and zeroes the level and target)
// and yields one output beat carrying the level after that tick and a flag that
// is set when a new target was drawn. Beats are handled one at a time by the
// sequencer in rwm_ctrl: after acceptance a restart passes through DECIDE and
// PUSH, a step toward the target through DECIDE, BRANCH and PUSH, and a tick
// that draws a new target also through SCALE and TARGET, BRANCH advancing the
// generator and SCALE holding the dependent scaling multiply. The next input
// beat is accepted once the sequencer is back in IDLE; a result still waiting
// in a full output register holds the sequencer until the downstream side
// takes it. A finished beat waits in the output register, so the next input
// beat is accepted while the previous result is still pending. seed_value is
// used only at the next restart; the step register applies from the next tick.
module random_walk_modulator_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] mod_value
    output logic        m_tuser,   // [0] new_target
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rwm_pkg::*;

    logic [31:0] seed_reg;
    logic [30:0] step_reg;
    logic        wr_en;
    rwm_cmd_t    cmd;
    rwm_stat_t   stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
            step_reg <= STEP_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_SEED: seed_reg <= pwdata;
                REG_STEP: step_reg <= pwdata[30:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SEED: prdata = seed_reg;
            REG_STEP: prdata = {1'b0, step_reg};
            default:  prdata = '0;
        endcase
    end

    rwm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rwm_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_restart (s_tdata[0]),
        .seed_value (seed_reg),
        .step_incr  (step_reg),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
